### rtl/core/sfpaf_pkg.sv
// ----------------------------------------------------------------------------
// sfpaf_pkg
// Types and constants shared by the asset formatter modules.
// ----------------------------------------------------------------------------
package sfpaf_pkg;

  localparam int AMOUNT_W    = 64;
  localparam int PREC_W      = 8;
  localparam int SYMBOL_W    = 56;
  localparam int CHAR_W      = 8;
  localparam int DIGITS      = 20;
  localparam int DIGIT_W     = 4;
  localparam int DIG_IDX_W   = $clog2(DIGITS);
  localparam int SYM_BYTES   = 7;
  localparam int SYM_IDX_W   = 3;
  localparam int BITS_STEP   = 4;
  localparam int STEPS       = AMOUNT_W / BITS_STEP;
  localparam int STEP_CNT_W  = $clog2(STEPS);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic signed [AMOUNT_W-1:0] amount;
    logic [PREC_W-1:0]          precision;
    logic [SYMBOL_W-1:0]        symbol_code;
  } asset_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              bad_symbol;
  } text_t;

  typedef struct packed {
    logic [DIGITS-1:0][DIGIT_W-1:0] digits;
    logic                           neg;
    logic [PREC_W-1:0]              prec;
    logic [SYMBOL_W-1:0]            sym;
    logic                           bad;
  } conv_job_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_ERR,
    E_SIGN,
    E_DIGIT,
    E_POINT,
    E_SPACE,
    E_SYM
  } emit_state_t;

endpackage

### rtl/core/sfpaf_bcd_cell.sv
// ----------------------------------------------------------------------------
// sfpaf_bcd_cell
// One decimal digit of the shift-and-add-3 converter; takes four bits a cycle
// from its lower neighbor while run is high and passes four bits on to the next digit.
// ----------------------------------------------------------------------------
module sfpaf_bcd_cell (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          run,
  input  logic [sfpaf_pkg::BITS_STEP-1:0] shift_in,
  output logic [sfpaf_pkg::BITS_STEP-1:0] shift_out,
  output logic [sfpaf_pkg::DIGIT_W-1:0]   digit
);

  logic [sfpaf_pkg::DIGIT_W-1:0] digit_next;

  always_comb begin
    logic [sfpaf_pkg::DIGIT_W-1:0] d;
    d = digit;
    shift_out = '0;
    for (int s = 0; s < sfpaf_pkg::BITS_STEP; s++) begin
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      shift_out[sfpaf_pkg::BITS_STEP-1-s] = d[sfpaf_pkg::DIGIT_W-1];
      d = {d[sfpaf_pkg::DIGIT_W-2:0], shift_in[sfpaf_pkg::BITS_STEP-1-s]};
    end
    digit_next = d;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digit <= '0;
    end else if (run) begin
      digit <= digit_next;
    end
  end

endmodule

### rtl/core/sfpaf_converter.sv
// ----------------------------------------------------------------------------
// sfpaf_converter
// Takes a request, forms the magnitude and checks the symbol, then shifts the
// magnitude through a row of digit cells four bits a cycle.
// ----------------------------------------------------------------------------
module sfpaf_converter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 asset_valid,
  output logic                 asset_stall,
  input  sfpaf_pkg::asset_t    asset,
  output logic                 job_valid,
  input  logic                 job_take,
  output sfpaf_pkg::conv_job_t job
);

  logic                                  running;
  logic                                  done;
  logic [sfpaf_pkg::STEP_CNT_W-1:0]      cnt;
  logic [sfpaf_pkg::AMOUNT_W-1:0]        shift;
  logic                                  neg;
  logic [sfpaf_pkg::PREC_W-1:0]          prec;
  logic [sfpaf_pkg::SYMBOL_W-1:0]        sym;
  logic                                  bad;
  logic                                  accept;
  logic [sfpaf_pkg::AMOUNT_W-1:0]        raw;
  logic [sfpaf_pkg::AMOUNT_W-1:0]        mag_in;
  logic                                  bad_in;
  logic [sfpaf_pkg::BITS_STEP-1:0]       chain [sfpaf_pkg::DIGITS];
  logic [sfpaf_pkg::DIGITS-1:0][sfpaf_pkg::DIGIT_W-1:0] digits;

  assign asset_stall = running | done;
  assign accept      = asset_valid & ~asset_stall;
  assign raw         = asset.amount;
  assign mag_in      = raw[sfpaf_pkg::AMOUNT_W-1] ? (~raw + 64'd1) : raw;

  always_comb begin
    logic [sfpaf_pkg::CHAR_W-1:0] c;
    bad_in = 1'b0;
    for (int k = 0; k < sfpaf_pkg::SYM_BYTES; k++) begin
      c = asset.symbol_code[k*sfpaf_pkg::CHAR_W +: sfpaf_pkg::CHAR_W];
      if (c != sfpaf_pkg::CH_NUL && !(c inside {[sfpaf_pkg::CH_A:sfpaf_pkg::CH_Z]})) begin
        bad_in = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      if (accept) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == sfpaf_pkg::STEP_CNT_W'(sfpaf_pkg::STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
      if (job_take) begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shift <= mag_in;
      neg   <= raw[sfpaf_pkg::AMOUNT_W-1];
      prec  <= asset.precision;
      sym   <= asset.symbol_code;
      bad   <= bad_in;
    end else if (running) begin
      shift <= shift << sfpaf_pkg::BITS_STEP;
    end
  end

  // digit row, least significant digit first
  for (genvar i = 0; i < sfpaf_pkg::DIGITS; i++) begin : g_cell
    logic [sfpaf_pkg::BITS_STEP-1:0] cell_in;
    if (i == 0) begin : g_first
      assign cell_in = shift[sfpaf_pkg::AMOUNT_W-1 -: sfpaf_pkg::BITS_STEP];
    end else begin : g_rest
      assign cell_in = chain[i-1];
    end
    sfpaf_bcd_cell u_cell (
      .clk       (clk),
      .load      (accept),
      .run       (running),
      .shift_in  (cell_in),
      .shift_out (chain[i]),
      .digit     (digits[i])
    );
  end

  assign job_valid  = done;
  assign job.digits = digits;
  assign job.neg    = neg;
  assign job.prec   = prec;
  assign job.sym    = sym;
  assign job.bad    = bad;

endmodule

### rtl/core/sfpaf_emitter.sv
// ----------------------------------------------------------------------------
// sfpaf_emitter
// Walks the converted digits and the symbol and sends one character a cycle,
// while text_stall is low, through an output register.
// ----------------------------------------------------------------------------
module sfpaf_emitter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_take,
  input  sfpaf_pkg::conv_job_t job,
  output logic                 text_valid,
  input  logic                 text_stall,
  output sfpaf_pkg::text_t     text
);

  sfpaf_pkg::emit_state_t state;
  sfpaf_pkg::emit_state_t state_next;
  sfpaf_pkg::emit_state_t start_state;

  logic [sfpaf_pkg::DIGITS-1:0][sfpaf_pkg::DIGIT_W-1:0] digits;
  logic [sfpaf_pkg::PREC_W-1:0]    prec;
  logic [sfpaf_pkg::SYMBOL_W-1:0]  sym;
  logic [sfpaf_pkg::DIG_IDX_W-1:0] dig_idx;
  logic [sfpaf_pkg::DIG_IDX_W-1:0] dig_idx_next;
  logic [sfpaf_pkg::SYM_IDX_W-1:0] sym_idx;
  logic [sfpaf_pkg::SYM_IDX_W-1:0] sym_idx_next;
  logic [sfpaf_pkg::SYM_IDX_W-1:0] sym_idx_p1;
  logic [sfpaf_pkg::DIG_IDX_W-1:0] msd;
  logic [sfpaf_pkg::DIG_IDX_W-1:0] pmin;
  logic [sfpaf_pkg::DIG_IDX_W-1:0] start_idx;
  logic [sfpaf_pkg::CHAR_W-1:0]    sym_cur;
  logic [sfpaf_pkg::CHAR_W-1:0]    sym_nxt;
  logic                            adv;
  sfpaf_pkg::text_t                text_cur;

  assign job_take   = job_valid && (state == sfpaf_pkg::E_IDLE);
  assign adv        = (state != sfpaf_pkg::E_IDLE) && (!text_valid || !text_stall);
  assign sym_idx_p1 = sym_idx + 1'b1;
  assign sym_cur    = sfpaf_pkg::CHAR_W'(sym >> {sym_idx, 3'b000});
  assign sym_nxt    = sfpaf_pkg::CHAR_W'(sym >> {sym_idx_p1, 3'b000});

  // first digit shown: highest nonzero digit or the precision, whichever is higher
  always_comb begin
    msd = '0;
    for (int k = 1; k < sfpaf_pkg::DIGITS; k++) begin
      if (job.digits[k] != '0) begin
        msd = sfpaf_pkg::DIG_IDX_W'(k);
      end
    end
    if (job.prec >= sfpaf_pkg::PREC_W'(sfpaf_pkg::DIGITS - 1)) begin
      pmin = sfpaf_pkg::DIG_IDX_W'(sfpaf_pkg::DIGITS - 1);
    end else begin
      pmin = job.prec[sfpaf_pkg::DIG_IDX_W-1:0];
    end
    start_idx = (msd > pmin) ? msd : pmin;
    if (job.bad) begin
      start_state = sfpaf_pkg::E_ERR;
    end else if (job.neg) begin
      start_state = sfpaf_pkg::E_SIGN;
    end else begin
      start_state = sfpaf_pkg::E_DIGIT;
    end
  end

  // next state
  always_comb begin
    state_next   = state;
    dig_idx_next = dig_idx;
    sym_idx_next = sym_idx;
    case (state)
      sfpaf_pkg::E_ERR: begin
        state_next = sfpaf_pkg::E_IDLE;
      end
      sfpaf_pkg::E_SIGN: begin
        state_next = sfpaf_pkg::E_DIGIT;
      end
      sfpaf_pkg::E_DIGIT: begin
        if (dig_idx == '0) begin
          state_next = sfpaf_pkg::E_SPACE;
        end else begin
          dig_idx_next = dig_idx - 1'b1;
          if (prec == sfpaf_pkg::PREC_W'(dig_idx)) begin
            state_next = sfpaf_pkg::E_POINT;
          end
        end
      end
      sfpaf_pkg::E_POINT: begin
        state_next = sfpaf_pkg::E_DIGIT;
      end
      sfpaf_pkg::E_SPACE: begin
        sym_idx_next = '0;
        state_next   = (sym_cur == sfpaf_pkg::CH_NUL) ? sfpaf_pkg::E_IDLE : sfpaf_pkg::E_SYM;
      end
      sfpaf_pkg::E_SYM: begin
        if (sym_nxt == sfpaf_pkg::CH_NUL) begin
          state_next = sfpaf_pkg::E_IDLE;
        end else begin
          sym_idx_next = sym_idx_p1;
        end
      end
      default: begin
        state_next = sfpaf_pkg::E_IDLE;
      end
    endcase
  end

  // character for the current state
  always_comb begin
    text_cur.character  = sfpaf_pkg::CH_NUL;
    text_cur.last       = 1'b0;
    text_cur.bad_symbol = 1'b0;
    case (state)
      sfpaf_pkg::E_ERR: begin
        text_cur.last       = 1'b1;
        text_cur.bad_symbol = 1'b1;
      end
      sfpaf_pkg::E_SIGN: begin
        text_cur.character = sfpaf_pkg::CH_MINUS;
      end
      sfpaf_pkg::E_DIGIT: begin
        text_cur.character = sfpaf_pkg::CH_ZERO + sfpaf_pkg::CHAR_W'(digits[dig_idx]);
      end
      sfpaf_pkg::E_POINT: begin
        text_cur.character = sfpaf_pkg::CH_POINT;
      end
      sfpaf_pkg::E_SPACE: begin
        text_cur.character = sfpaf_pkg::CH_SPACE;
        text_cur.last      = (sym_cur == sfpaf_pkg::CH_NUL);
      end
      sfpaf_pkg::E_SYM: begin
        text_cur.character = sym_cur;
        text_cur.last      = (sym_nxt == sfpaf_pkg::CH_NUL);
      end
      default: begin
        text_cur.character = sfpaf_pkg::CH_NUL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sfpaf_pkg::E_IDLE;
      text_valid <= 1'b0;
    end else begin
      if (job_take) begin
        state <= start_state;
      end else if (adv) begin
        state <= state_next;
      end
      if (adv) begin
        text_valid <= 1'b1;
      end else if (!text_stall) begin
        text_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      digits  <= job.digits;
      prec    <= job.prec;
      sym     <= job.sym;
      dig_idx <= start_idx;
      sym_idx <= '0;
    end else if (adv) begin
      dig_idx <= dig_idx_next;
      sym_idx <= sym_idx_next;
    end
    if (adv) begin
      text <= text_cur;
    end
  end

endmodule

### rtl/core/signed_fixed_point_asset_formatter.sv
// ----------------------------------------------------------------------------
// signed_fixed_point_asset_formatter
// Formats a signed fixed-point amount and its symbol as ASCII text, one
// character per result.
// ----------------------------------------------------------------------------
// path: a request that is taken goes through the digit row at four bits a cycle,
//   one handoff to the character stream and one output register
// throughput: one character a cycle while text_stall is low; a new request is
//   taken once the last one has left the digit row for the character stream
// reset: clears control only; no stored data survives between requests
module signed_fixed_point_asset_formatter (
  input  logic              clk,
  input  logic              rst,
  input  logic              asset_valid,
  output logic              asset_stall,
  input  sfpaf_pkg::asset_t asset,
  output logic              text_valid,
  input  logic              text_stall,
  output sfpaf_pkg::text_t  text
);

  logic                 job_valid;
  logic                 job_take;
  sfpaf_pkg::conv_job_t job;

  sfpaf_converter u_converter (
    .clk         (clk),
    .rst         (rst),
    .asset_valid (asset_valid),
    .asset_stall (asset_stall),
    .asset       (asset),
    .job_valid   (job_valid),
    .job_take    (job_take),
    .job         (job)
  );

  sfpaf_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job_take   (job_take),
    .job        (job),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text)
  );

endmodule
